>>> src/assert_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, silenced while reset is low.
`define MFVN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MFVN_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/mfvn_pkg.sv
package mfvn_pkg;

    localparam int MAX_VERTICES     = 1024;
    localparam int VIDX_W           = $clog2(MAX_VERTICES);
    localparam int INDEX_BITS       = 10;
    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int ACCUM_BITS       = 20;
    localparam int NORM_W           = 16;

    localparam int DIFF_W    = COORD_BITS + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int CUT_W     = 30;
    localparam int SHIFT_MAX = CROSS_W - CUT_W;
    localparam int SQ_W      = 2 * CUT_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int NUM_W     = CUT_W + NORMAL_FRAC_BITS + 1;
    localparam int Q_W       = NORMAL_FRAC_BITS + 1;
    localparam int POS_W     = 3 * COORD_BITS;
    localparam int ACC_W     = 3 * ACCUM_BITS;
    localparam int ASUM_W    = ACCUM_BITS + 1;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TRI  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic KIND_FACE   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    typedef struct packed {
        logic [1:0]                    command;
        logic [INDEX_BITS-1:0]         vertex_index;
        logic signed [COORD_BITS-1:0]  pos_x;
        logic signed [COORD_BITS-1:0]  pos_y;
        logic signed [COORD_BITS-1:0]  pos_z;
        logic [INDEX_BITS-1:0]         corner_a;
        logic [INDEX_BITS-1:0]         corner_b;
        logic [INDEX_BITS-1:0]         corner_c;
    } t_in_req;

    typedef struct packed {
        logic                      result_kind;
        logic signed [NORM_W-1:0]  norm_x;
        logic signed [NORM_W-1:0]  norm_y;
        logic signed [NORM_W-1:0]  norm_z;
        logic                      degenerate;
    } t_out_res;

    typedef struct packed {
        logic signed [NORM_W-1:0]  x;
        logic signed [NORM_W-1:0]  y;
        logic signed [NORM_W-1:0]  z;
        logic                      degen;
    } t_norm_res;

endpackage

>>> src/mfvn_ram.sv
module mfvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> src/mfvn_norm.sv
module mfvn_norm
    import mfvn_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [CROSS_W-1:0] i_vx,
    input  logic signed [CROSS_W-1:0] i_vy,
    input  logic signed [CROSS_W-1:0] i_vz,
    output logic                      o_done,
    output t_norm_res                 o_res
);

    localparam logic [2:0] N_IDLE = 3'd0;
    localparam logic [2:0] N_SQ   = 3'd1;
    localparam logic [2:0] N_ROOT = 3'd2;
    localparam logic [2:0] N_DIV  = 3'd3;
    localparam logic [2:0] N_DONE = 3'd4;

    logic [2:0]         r_state;
    logic [CUT_W-1:0]   r_mag [3];
    logic [2:0]         r_neg;
    logic [1:0]         r_idx;
    logic [SUM_W-1:0]   r_x;
    logic [SUM_W-1:0]   r_r;
    logic [SUM_W-1:0]   r_bit;
    logic [4:0]         r_cnt;
    logic [NUM_W-1:0]   r_rem;
    logic [Q_W-1:0]     r_q;
    logic [3:0]         r_qbit;
    logic signed [NORM_W-1:0] r_n [3];
    logic               r_degen;

    logic [CROSS_W-1:0] mag_full [3];
    logic [CROSS_W-1:0] mag_or;
    logic [2:0]         shift;
    logic [SQ_W-1:0]    sq;
    logic [SUM_W-1:0]   trial_root;
    logic [ROOT_W-1:0]  len;
    logic [NUM_W-1:0]   trial_div;
    logic [NUM_W-1:0]   num_init;
    logic [Q_W-1:0]     q_final;
    logic [NORM_W-1:0]  q_fin_ext;

    always_comb begin
        mag_full[0] = i_vx[CROSS_W-1] ? CROSS_W'(-i_vx) : CROSS_W'(i_vx);
        mag_full[1] = i_vy[CROSS_W-1] ? CROSS_W'(-i_vy) : CROSS_W'(i_vy);
        mag_full[2] = i_vz[CROSS_W-1] ? CROSS_W'(-i_vz) : CROSS_W'(i_vz);
        mag_or = mag_full[0] | mag_full[1] | mag_full[2];
        shift = '0;
        // smallest shift that brings every magnitude below the cut limit
        for (int k = 1; k <= SHIFT_MAX; k++) begin
            if ((mag_or >> (CUT_W - 1 + k)) != '0) begin
                shift = 3'(k);
            end
        end
    end

    assign sq         = SQ_W'(r_mag[r_idx]) * SQ_W'(r_mag[r_idx]);
    assign trial_root = r_r + r_bit;
    assign len        = r_r[ROOT_W-1:0];
    assign trial_div  = NUM_W'(len) << r_qbit;
    assign num_init   = (NUM_W'(r_mag[r_idx]) << NORMAL_FRAC_BITS) + NUM_W'(len >> 1);

    // complete the quotient with its last bit, ready to be signed
    assign q_final   = (r_rem >= trial_div) ? (r_q | (Q_W'(1) << r_qbit)) : r_q;
    assign q_fin_ext = NORM_W'(q_final);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            unique case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= CUT_W'(mag_full[i] >> shift);
                        end
                        r_neg   <= {i_vz[CROSS_W-1], i_vy[CROSS_W-1], i_vx[CROSS_W-1]};
                        r_idx   <= '0;
                        r_x     <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    r_x <= r_x + SUM_W'(sq);
                    if (r_idx == 2'd2) begin
                        r_r     <= '0;
                        r_bit   <= SUM_W'(1) << (SUM_W - 2);
                        r_cnt   <= '0;
                        r_state <= N_ROOT;
                    end else begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                N_ROOT: begin
                    // one result bit per cycle
                    if (r_x >= trial_root) begin
                        r_x <= r_x - trial_root;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(ROOT_STEPS - 1)) begin
                        r_idx   <= '0;
                        r_state <= N_DIV;
                        r_qbit  <= 4'(Q_W);
                    end
                end
                N_DIV: begin
                    if (len == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_n[i] <= '0;
                        end
                        r_degen <= 1'b1;
                        r_state <= N_DONE;
                    end else if (r_qbit == 4'(Q_W)) begin
                        // load numerator with rounding term
                        r_rem  <= num_init;
                        r_q    <= '0;
                        r_qbit <= 4'(Q_W - 1);
                    end else begin
                        if (r_rem >= trial_div) begin
                            r_rem       <= r_rem - trial_div;
                            r_q[r_qbit] <= 1'b1;
                        end
                        if (r_qbit == '0) begin
                            r_qbit     <= 4'(Q_W);
                            r_n[r_idx] <= r_neg[r_idx] ? -$signed(q_fin_ext)
                                                       : $signed(q_fin_ext);
                        end else begin
                            r_qbit <= r_qbit - 4'd1;
                        end
                    end
                    if (len != '0 && r_qbit == '0) begin
                        r_idx <= r_idx + 2'd1;
                        if (r_idx == 2'd2) begin
                            r_degen <= 1'b0;
                            r_state <= N_DONE;
                        end
                    end
                end
                N_DONE: begin
                    r_state <= N_IDLE;
                end
                default: begin
                    r_state <= N_IDLE;
                end
            endcase
        end
    end

    assign o_done    = (r_state == N_DONE);
    assign o_res.x   = r_n[0];
    assign o_res.y   = r_n[1];
    assign o_res.z   = r_n[2];
    assign o_res.degen = r_degen;

endmodule

>>> src/mfvn_front.sv
module mfvn_front
    import mfvn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_in_req i_in_req,
    input  logic    i_hold,
    output logic    o_q_valid,
    output t_in_req o_q_req,
    input  logic    i_q_pop
);

    t_in_req    r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       accept;
    logic       push;
    logic       pop;

    assign o_in_stall = i_hold || (r_cnt == 2'd2);
    assign accept     = i_in_valid && !o_in_stall;
    // drop unknown commands at the door
    assign push       = accept && (i_in_req.command != CMD_NONE);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_req    = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= i_in_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

>>> src/mfvn_back.sv
module mfvn_back
    import mfvn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_in_req  i_q_req,
    output logic     o_q_pop,
    output logic     o_hold,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_res
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_PA   = 4'd2;
    localparam logic [3:0] S_PB   = 4'd3;
    localparam logic [3:0] S_PC   = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_RDV  = 4'd6;
    localparam logic [3:0] S_NGO  = 4'd7;
    localparam logic [3:0] S_NWT  = 4'd8;
    localparam logic [3:0] S_EMIT = 4'd9;
    localparam logic [3:0] S_ARD  = 4'd10;
    localparam logic [3:0] S_AWR  = 4'd11;

    logic [3:0]   r_state, n_state;
    logic [VIDX_W-1:0] r_clr;
    t_in_req      r_req;
    logic [POS_W-1:0] r_pa;
    logic signed [DIFF_W-1:0]  r_da [3];
    logic signed [DIFF_W-1:0]  r_db [3];
    logic signed [CROSS_W-1:0] r_cr [3];
    logic [2:0]   r_step;
    logic [1:0]   r_corner;
    t_norm_res    r_nres;
    logic         r_out_valid;
    t_out_res     r_out;

    logic              pos_we, acc_we;
    logic [VIDX_W-1:0] pos_waddr, pos_raddr, acc_waddr, acc_raddr;
    logic [POS_W-1:0]  pos_wdata, pos_rdata;
    logic [ACC_W-1:0]  acc_wdata, acc_rdata;
    logic              norm_start, norm_done;
    t_norm_res         norm_res;
    logic              out_free;
    logic [VIDX_W-1:0] corner_addr;
    logic signed [DIFF_W-1:0]  op1, op2;
    logic signed [PROD_W-1:0]  prod;
    logic signed [CROSS_W-1:0] prod_ext;
    logic signed [NORM_W-1:0]  nsel [3];

    mfvn_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    mfvn_ram #(.WIDTH(ACC_W), .DEPTH(MAX_VERTICES)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    mfvn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_vx    (r_cr[0]),
        .i_vy    (r_cr[1]),
        .i_vz    (r_cr[2]),
        .o_done  (norm_done),
        .o_res   (norm_res)
    );

    function automatic logic signed [DIFF_W-1:0] diff_of(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    endfunction

    function automatic logic [ACCUM_BITS-1:0] sat_add(
        input logic [ACCUM_BITS-1:0]   acc,
        input logic signed [NORM_W-1:0] n
    );
        logic signed [ASUM_W-1:0] s;
        s = $signed({acc[ACCUM_BITS-1], acc}) + ASUM_W'(n);
        if (s[ASUM_W-1] != s[ASUM_W-2]) begin
            return s[ASUM_W-1] ? {1'b1, {(ACCUM_BITS-1){1'b0}}}
                               : {1'b0, {(ACCUM_BITS-1){1'b1}}};
        end
        return s[ACCUM_BITS-1:0];
    endfunction

    function automatic logic signed [CROSS_W-1:0] acc_ext(input logic [ACCUM_BITS-1:0] a);
        return $signed({{(CROSS_W-ACCUM_BITS){a[ACCUM_BITS-1]}}, a});
    endfunction

    assign out_free = !r_out_valid || !i_out_stall;
    assign nsel[0]  = r_nres.x;
    assign nsel[1]  = r_nres.y;
    assign nsel[2]  = r_nres.z;

    always_comb begin
        unique case (r_corner)
            2'd0:    corner_addr = r_req.corner_a[VIDX_W-1:0];
            2'd1:    corner_addr = r_req.corner_b[VIDX_W-1:0];
            default: corner_addr = r_req.corner_c[VIDX_W-1:0];
        endcase
    end

    // cross product terms: even steps set, odd steps subtract
    always_comb begin
        unique case (r_step)
            3'd0:    begin op1 = r_da[1]; op2 = r_db[2]; end
            3'd1:    begin op1 = r_da[2]; op2 = r_db[1]; end
            3'd2:    begin op1 = r_da[2]; op2 = r_db[0]; end
            3'd3:    begin op1 = r_da[0]; op2 = r_db[2]; end
            3'd4:    begin op1 = r_da[0]; op2 = r_db[1]; end
            default: begin op1 = r_da[1]; op2 = r_db[0]; end
        endcase
    end
    assign prod     = op1 * op2;
    assign prod_ext = CROSS_W'(prod);

    always_comb begin
        n_state    = r_state;
        o_q_pop    = 1'b0;
        pos_we     = 1'b0;
        pos_waddr  = i_q_req.vertex_index[VIDX_W-1:0];
        pos_wdata  = {i_q_req.pos_x, i_q_req.pos_y, i_q_req.pos_z};
        pos_raddr  = i_q_req.corner_a[VIDX_W-1:0];
        acc_we     = 1'b0;
        acc_waddr  = r_clr;
        acc_wdata  = '0;
        acc_raddr  = i_q_req.vertex_index[VIDX_W-1:0];
        norm_start = 1'b0;
        unique case (r_state)
            S_CLR: begin
                acc_we = 1'b1;
                if (r_clr == VIDX_W'(MAX_VERTICES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    priority case (i_q_req.command)
                        CMD_LOAD: pos_we  = 1'b1;
                        CMD_TRI:  n_state = S_PA;
                        CMD_READ: n_state = S_RDV;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_PA: begin
                pos_raddr = r_req.corner_b[VIDX_W-1:0];
                n_state   = S_PB;
            end
            S_PB: begin
                pos_raddr = r_req.corner_c[VIDX_W-1:0];
                n_state   = S_PC;
            end
            S_PC:  n_state = S_MUL;
            S_MUL: begin
                if (r_step == 3'd5) begin
                    n_state = S_NGO;
                end
            end
            S_RDV: n_state = S_NGO;
            S_NGO: begin
                norm_start = 1'b1;
                n_state    = S_NWT;
            end
            S_NWT: begin
                if (norm_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = (r_req.command == CMD_TRI) ? S_ARD : S_IDLE;
                end
            end
            S_ARD: begin
                acc_raddr = corner_addr;
                n_state   = S_AWR;
            end
            S_AWR: begin
                acc_we    = 1'b1;
                acc_waddr = corner_addr;
                acc_wdata = {sat_add(acc_rdata[ACC_W-1 -: ACCUM_BITS], nsel[0]),
                             sat_add(acc_rdata[ACC_W-1-ACCUM_BITS -: ACCUM_BITS], nsel[1]),
                             sat_add(acc_rdata[ACCUM_BITS-1:0], nsel[2])};
                n_state   = (r_corner == 2'd2) ? S_IDLE : S_ARD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + VIDX_W'(1);
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_req <= i_q_req;
        end
        unique case (r_state)
            S_PA: r_pa <= pos_rdata;
            S_PB: begin
                for (int i = 0; i < 3; i++) begin
                    r_da[i] <= diff_of(r_pa[POS_W-1-i*COORD_BITS -: COORD_BITS],
                                       pos_rdata[POS_W-1-i*COORD_BITS -: COORD_BITS]);
                end
            end
            S_PC: begin
                for (int i = 0; i < 3; i++) begin
                    r_db[i] <= diff_of(r_pa[POS_W-1-i*COORD_BITS -: COORD_BITS],
                                       pos_rdata[POS_W-1-i*COORD_BITS -: COORD_BITS]);
                end
                r_step <= '0;
            end
            S_MUL: begin
                if (!r_step[0]) begin
                    r_cr[r_step[2:1]] <= prod_ext;
                end else begin
                    r_cr[r_step[2:1]] <= r_cr[r_step[2:1]] - prod_ext;
                end
                r_step <= r_step + 3'd1;
            end
            S_RDV: begin
                r_cr[0] <= acc_ext(acc_rdata[ACC_W-1 -: ACCUM_BITS]);
                r_cr[1] <= acc_ext(acc_rdata[ACC_W-1-ACCUM_BITS -: ACCUM_BITS]);
                r_cr[2] <= acc_ext(acc_rdata[ACCUM_BITS-1:0]);
            end
            S_NWT: begin
                if (norm_done) begin
                    r_nres <= norm_res;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out.result_kind <= (r_req.command == CMD_TRI) ? KIND_FACE : KIND_VERTEX;
                    r_out.norm_x      <= r_nres.x;
                    r_out.norm_y      <= r_nres.y;
                    r_out.norm_z      <= r_nres.z;
                    r_out.degenerate  <= r_nres.degen;
                    r_corner          <= 2'd0;
                end
            end
            S_AWR: r_corner <= r_corner + 2'd1;
            default: ;
        endcase
    end

    assign o_hold      = (r_state == S_CLR);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

>>> src/mesh_face_vertex_normals_top.sv
// Mesh normal unit. A load request stores a Q8.8 vertex position; a triangle
// request reads its three corners, emits the unit face normal (Q1.14) and adds
// it, saturating, into the normal accumulator of each corner; a read request
// emits the normalized accumulated normal of one vertex. Requests with command
// 3 are taken and dropped. After reset all 1024 entries of the accumulator memory
// are cleared, one entry per cycle, while o_in_stall is high. A two-entry queue
// parts the input from the sequencer. The sequencer works one request at a time:
// a load is written as it is popped; the work of a triangle or a read is set by
// the shared normalizer (3 squaring steps, 31 square-root steps and a division
// for each component) plus, for a triangle, three position reads, six multiplies
// and three accumulator read-modify-writes on single memory ports.
module mesh_face_vertex_normals_top
    import mfvn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_res
);

    logic    q_valid;
    t_in_req q_req;
    logic    q_pop;
    logic    hold;

    mfvn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .i_hold     (hold),
        .o_q_valid  (q_valid),
        .o_q_req    (q_req),
        .i_q_pop    (q_pop)
    );

    mfvn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_req     (q_req),
        .o_q_pop     (q_pop),
        .o_hold      (hold),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

endmodule

>>> src/mfvn_checker.sv
`include "assert_macros.svh"

module mfvn_checker
    import mfvn_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input t_in_req  i_in_req,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_out_res o_out_res
);

    `MFVN_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_res), "stalled result changed")

    `MFVN_ASSERT(a_degen_zero, i_clk, i_rst_n, o_out_valid && o_out_res.degenerate |-> o_out_res.norm_x == 0 && o_out_res.norm_y == 0 && o_out_res.norm_z == 0, "degenerate result with nonzero normal")

    `MFVN_ASSERT(a_unit_range, i_clk, i_rst_n, o_out_valid |-> o_out_res.norm_x <= 16384 && o_out_res.norm_x >= -16384 && o_out_res.norm_y <= 16384 && o_out_res.norm_y >= -16384 && o_out_res.norm_z <= 16384 && o_out_res.norm_z >= -16384, "normal component out of unit range")

    `MFVN_ASSERT(a_clear_stall, i_clk, i_rst_n, $rose(i_rst_n) |-> o_in_stall, "request taken during accumulator clear")

endmodule

bind mesh_face_vertex_normals_top mfvn_checker u_mfvn_checker (.*);
